// ===== rtl/core/sst_pkg.sv =====
// Shared types and constants for the stepper step timer.
// Holds the word structs, the state struct and the command and register codes.
// No dependencies.
`default_nettype none

package sst_pkg;

  localparam int POS_WIDTH      = 16;
  localparam int COUNT_WIDTH    = 32;
  localparam int INTERVAL_WIDTH = 32;
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 32;

  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_ROTATE    = 2'd1;
  localparam logic [1:0] KIND_ROTATE_TO = 2'd2;
  localparam logic [1:0] KIND_STOP      = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEPS_PER_REV = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL = 8'd1;

  localparam logic [POS_WIDTH-1:0]      STEPS_PER_REV_RESET = 16'd200;
  localparam logic [INTERVAL_WIDTH-1:0] STEP_INTERVAL_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   direction;
    logic [COUNT_WIDTH-1:0] step_count;
    logic [POS_WIDTH-1:0]   target_position;
  } sst_in_t;

  typedef struct packed {
    logic                 step_pulse;
    logic                 step_dir;
    logic [POS_WIDTH-1:0] position;
    logic                 done_res;
    logic                 running;
  } sst_out_t;

  typedef struct packed {
    logic                      moving;
    logic                      dir_reg;
    logic [COUNT_WIDTH-1:0]    remaining;
    logic [INTERVAL_WIDTH-1:0] elapsed;
    logic [POS_WIDTH-1:0]      step_position;
  } sst_state_t;

  function automatic logic [POS_WIDTH-1:0] rev_len(input logic [POS_WIDTH-1:0] spr);
    rev_len = (spr == '0) ? POS_WIDTH'(1) : spr;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sst_step_logic.sv =====
// Next-state and result logic for one word of the stepper step timer.
// Purely combinational; depends on sst_pkg for the word and state structs.
`default_nettype none

module sst_step_logic (
  input  sst_pkg::sst_state_t                      state,
  input  sst_pkg::sst_in_t                         item,
  input  logic [sst_pkg::POS_WIDTH-1:0]            steps_per_rev,
  input  logic [sst_pkg::INTERVAL_WIDTH-1:0]       step_interval,
  output sst_pkg::sst_state_t                      state_next,
  output sst_pkg::sst_out_t                        result
);
  import sst_pkg::*;

  logic [POS_WIDTH-1:0]      n;
  logic [POS_WIDTH:0]        pos_inc;
  logic [POS_WIDTH-1:0]      pos_adv;
  logic [INTERVAL_WIDTH-1:0] lim;
  logic [INTERVAL_WIDTH-1:0] elapsed_inc;
  logic [POS_WIDTH-1:0]      span;
  logic                      pulse;
  logic                      done;

  always_comb begin
    n       = rev_len(steps_per_rev);
    pos_inc = {1'b0, state.step_position} + (POS_WIDTH+1)'(1);
    if (state.dir_reg == 1'b0) begin
      pos_adv = (pos_inc >= {1'b0, n}) ? '0 : pos_inc[POS_WIDTH-1:0];
    end else begin
      pos_adv = (state.step_position == '0 || state.step_position >= n)
                ? n - POS_WIDTH'(1) : state.step_position - POS_WIDTH'(1);
    end
    lim         = (step_interval == '0) ? INTERVAL_WIDTH'(1) : step_interval;
    elapsed_inc = (state.elapsed == '1) ? state.elapsed
                                         : state.elapsed + INTERVAL_WIDTH'(1);
    span        = (state.step_position >= item.target_position)
                  ? state.step_position - item.target_position
                  : item.target_position - state.step_position;
  end

  always_comb begin
    state_next = state;
    pulse      = 1'b0;
    done       = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        if (state.moving) begin
          if (elapsed_inc >= lim) begin
            state_next.elapsed       = '0;
            pulse                    = 1'b1;
            state_next.step_position = pos_adv;
            if (state.remaining != '0) begin
              state_next.remaining = state.remaining - COUNT_WIDTH'(1);
              if (state.remaining == COUNT_WIDTH'(1)) begin
                state_next.moving = 1'b0;
                done              = 1'b1;
              end
            end
          end else begin
            state_next.elapsed = elapsed_inc;
          end
        end
      end
      KIND_ROTATE: begin
        state_next.elapsed   = '0;
        state_next.dir_reg   = item.direction;
        state_next.remaining = item.step_count;
        state_next.moving    = 1'b1;
      end
      KIND_ROTATE_TO: begin
        state_next.elapsed   = '0;
        state_next.dir_reg   = item.direction;
        state_next.remaining = COUNT_WIDTH'(span);
        state_next.moving    = (span != '0);
        done                 = (span == '0);
      end
      KIND_STOP: begin
        state_next.moving = 1'b0;
      end
      default: begin
        state_next = state;
      end
    endcase
    result.step_pulse = pulse;
    result.step_dir   = pulse & state.dir_reg;
    result.position   = state_next.step_position;
    result.done_res   = done;
    result.running    = state_next.moving;
  end

endmodule

`default_nettype wire

// ===== rtl/core/stepper_step_timer.sv =====
// Top level of the stepper step timer: handshake stages, registers and state.
// Depends on sst_pkg and sst_step_logic.
//
// Words enter on the in channel (valid/ready): a tick, a relative rotate,
// an absolute rotate or a stop. Every accepted word yields exactly one
// result word on the out channel (valid/ready) carrying the step pulse, its
// direction, the position, a done flag and the running flag.
// Configuration is a plain write port: cfg_we, cfg_index (0 steps per
// revolution, 1 step interval) and cfg_data; other indexes are ignored.
// Write it only while no word is in flight.
// A word passes through the input register, then through the step logic
// into the result register. The block takes one word per cycle while the
// receiver keeps taking results; the motor state feeds back through the
// combinational step logic, so each word sees the state the last one left.
// When the receiver stalls, the result register holds and the input
// register fills; input ready drops only when both are occupied.
// Synchronous reset empties both stages, stops the motor, zeroes position,
// timer and count, and sets 200 steps per revolution and an interval of 1000.
`default_nettype none

module stepper_step_timer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sst_pkg::sst_in_t                    in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sst_pkg::sst_out_t                   out_word,
  input  logic                                cfg_we,
  input  logic [sst_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sst_pkg::*;

  logic                      s1_valid;
  sst_in_t                   s1_word;
  logic                      out_free;
  logic                      advance;
  logic [POS_WIDTH-1:0]      steps_per_rev;
  logic [INTERVAL_WIDTH-1:0] step_interval;
  sst_state_t                state;
  sst_state_t                state_next;
  sst_out_t                  result;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  sst_step_logic u_step (
    .state         (state),
    .item          (s1_word),
    .steps_per_rev (steps_per_rev),
    .step_interval (step_interval),
    .state_next    (state_next),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      steps_per_rev <= STEPS_PER_REV_RESET;
      step_interval <= STEP_INTERVAL_RESET;
      state         <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_STEPS_PER_REV) begin
        steps_per_rev <= cfg_data[POS_WIDTH-1:0];
      end
      if (cfg_we && cfg_index == CFG_STEP_INTERVAL) begin
        step_interval <= cfg_data[INTERVAL_WIDTH-1:0];
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_word;
    end
    if (advance) begin
      out_word <= result;
    end
  end

  a_dir_needs_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.step_pulse |-> !out_word.step_dir)
    else $error("step direction reported without a pulse");

  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.done_res |-> !out_word.running)
    else $error("move reported done while still running");

  a_pulse_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.step_pulse |-> out_word.position < rev_len(steps_per_rev))
    else $error("position outside the revolution after a step");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_word))
    else $error("input stage lost its word while the output stalled");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance && !$past(rst) |=> $stable(state))
    else $error("motor state changed without a word");

endmodule

`default_nettype wire

// ===== verif/tb_stepper_step_timer.sv =====
// Self-checking testbench for the stepper step timer: directed and random command words,
// each result word checked against an in-bench motor predictor.
// Depends on sst_pkg and stepper_step_timer.
module tb_stepper_step_timer;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sst_in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sst_out_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sst_in_t cmd_backlog[$];
  sst_out_t due_status[$];
  sst_out_t status_want;
  int fault_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  logic [POS_WIDTH-1:0] spr_q = STEPS_PER_REV_RESET;
  logic [INTERVAL_WIDTH-1:0] interval_q = STEP_INTERVAL_RESET;
  logic m_moving = 1'b0;
  logic m_dir = 1'b0;
  logic [COUNT_WIDTH-1:0] m_remaining = '0;
  logic [INTERVAL_WIDTH-1:0] m_elapsed = '0;
  logic [POS_WIDTH-1:0] m_pos = '0;

  stepper_step_timer u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic sst_out_t motor_step(sst_in_t w);
    sst_out_t r;
    logic [INTERVAL_WIDTH-1:0] lim;
    logic [POS_WIDTH:0] n;
    logic [POS_WIDTH-1:0] span;
    r = '0;
    case (w.kind)
      KIND_TICK: if (m_moving) begin
        lim = (interval_q == '0) ? INTERVAL_WIDTH'(1) : interval_q;
        if (m_elapsed != '1) m_elapsed = m_elapsed + 1'b1;
        if (m_elapsed >= lim) begin
          m_elapsed = '0;
          r.step_pulse = 1'b1;
          r.step_dir = m_dir;
          n = (spr_q == '0) ? (POS_WIDTH+1)'(1) : {1'b0, spr_q};
          if (!m_dir) begin
            m_pos = ({1'b0, m_pos} + 1'b1 >= n) ? '0 : m_pos + 1'b1;
          end else begin
            m_pos = (m_pos == '0 || {1'b0, m_pos} >= n) ? POS_WIDTH'(n - 1'b1) : m_pos - 1'b1;
          end
          if (m_remaining != '0) begin
            m_remaining = m_remaining - 1'b1;
            if (m_remaining == '0) begin
              m_moving = 1'b0;
              r.done_res = 1'b1;
            end
          end
        end
      end
      KIND_ROTATE: begin
        m_elapsed = '0;
        m_dir = w.direction;
        m_remaining = w.step_count;
        m_moving = 1'b1;
      end
      KIND_ROTATE_TO: begin
        span = (m_pos >= w.target_position) ? m_pos - w.target_position
                                            : w.target_position - m_pos;
        m_elapsed = '0;
        m_dir = w.direction;
        m_remaining = COUNT_WIDTH'(span);
        m_moving = (span != '0);
        r.done_res = (span == '0);
      end
      KIND_STOP: begin
        m_moving = 1'b0;
      end
    endcase
    r.position = m_pos;
    r.running = m_moving;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_status.push_back(motor_step(in_word));
      if (!(in_valid && !in_ready)) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_word <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_status.size() == 0) begin
          $display("%0t: result word %h with none expected", $time, out_word);
          fault_count++;
        end else begin
          status_want = due_status.pop_front();
          check_field("step_pulse", 32'(status_want.step_pulse), 32'(out_word.step_pulse));
          check_field("step_dir", 32'(status_want.step_dir), 32'(out_word.step_dir));
          check_field("position", 32'(status_want.position), 32'(out_word.position));
          check_field("done_res", 32'(status_want.done_res), 32'(out_word.done_res));
          check_field("running", 32'(status_want.running), 32'(out_word.running));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_cmd(logic [1:0] kind, logic dir, logic [31:0] count, logic [15:0] target);
    sst_in_t w;
    w.kind = kind;
    w.direction = dir;
    w.step_count = count;
    w.target_position = target;
    cmd_backlog.push_back(w);
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_cmd(KIND_TICK, 1'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || due_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_STEPS_PER_REV) spr_q = data[POS_WIDTH-1:0];
    else if (idx == CFG_STEP_INTERVAL) interval_q = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] spr, logic [CFG_DATA_W-1:0] interval);
    settle();
    write_reg(CFG_STEPS_PER_REV, spr);
    write_reg(CFG_STEP_INTERVAL, interval);
    @(negedge clk);
  endtask

  task automatic queue_random(int n);
    int pushed;
    int pick;
    int ticks;
    logic [31:0] count;
    logic [15:0] target;
    pushed = 0;
    while (pushed < n) begin
      pick = $urandom_range(99);
      count = $urandom_range(1, 12);
      case ($urandom_range(9))
        0: count = '0;
        1: count = $urandom;
        2: count = '1;
        default: ;
      endcase
      target = (spr_q == '0 || $urandom_range(3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(spr_q - 1));
      if (pick < 45) queue_cmd(KIND_ROTATE, 1'($urandom), count, 16'($urandom));
      else if (pick < 80) queue_cmd(KIND_ROTATE_TO, 1'($urandom), $urandom, target);
      else if (pick < 90) queue_cmd(KIND_STOP, 1'($urandom), $urandom, 16'($urandom));
      else queue_ticks(1);
      ticks = $urandom_range(24);
      queue_ticks(ticks);
      pushed += 1 + ticks;
    end
  endtask

  task automatic run_phase(logic [31:0] spr, logic [31:0] interval, int idle, int stall, int n);
    set_regs(spr, interval);
    idle_pct = idle;
    stall_pct = stall;
    queue_random(n / 2);
    settle();
    queue_random(n - n / 2);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_ticks(1);
    queue_cmd(KIND_STOP, 1'b0, '0, '0);
    queue_cmd(KIND_ROTATE_TO, 1'b1, '0, '0);
    queue_cmd(KIND_ROTATE, 1'b0, '0, '0);
    queue_ticks(2);
    queue_cmd(KIND_STOP, 1'b1, '1, '1);
    queue_ticks(1);

    set_regs(32'hFFFF_0000, 32'd0);
    queue_cmd(KIND_ROTATE, 1'b0, 32'd2, '0);
    queue_ticks(3);

    set_regs(32'h0001_000A, 32'd1);
    write_reg(CFG_UNMAPPED_LO, 32'd3);
    write_reg(CFG_UNMAPPED_HI, 32'd5);
    @(negedge clk);
    queue_cmd(KIND_ROTATE, 1'b0, '1, '0);
    queue_ticks(8);
    queue_cmd(KIND_STOP, 1'b0, '0, '0);

    set_regs(32'd4, 32'd1);
    queue_cmd(KIND_ROTATE, 1'b0, 32'd1, '0);
    queue_ticks(1);

    set_regs(32'd65535, 32'd1);
    queue_cmd(KIND_ROTATE_TO, 1'b1, '0, 16'hFFFF);
    queue_ticks(1);
    queue_cmd(KIND_STOP, 1'b0, '0, '0);

    set_regs(32'd9, 32'd1);
    queue_cmd(KIND_ROTATE, 1'b1, 32'd1, '0);
    queue_ticks(1);

    run_phase(32'd200, 32'd1, 0, 0, 200);
    run_phase(32'd65535, 32'd2, 60, 0, 200);
    run_phase(32'd3, 32'd0, 0, 60, 200);
    run_phase(32'd1, 32'd5, 11, 11, 200);
    run_phase(32'd12, 32'hFFFF_FFFF, 0, 0, 200);
    run_phase(32'd0, 32'd3, 60, 0, 200);
    run_phase(32'd50, 32'd7, 0, 60, 200);
    run_phase(32'd65535, 32'd1, 11, 11, 200);

    settle();
    repeat (8) @(negedge clk);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
